### rtl/core/mpds_pkg.sv
// shared types, sizes and the level-pair slot table for module path delay select
// no dependencies; imported by the top and classify modules
`default_nettype none

package mpds_pkg;

  localparam int NUM_PATHS   = 16;
  localparam int NUM_SLOTS   = 12;
  localparam int VEC_WIDTH   = 32;
  localparam int DELAY_WIDTH = 32;

  localparam int PORT_W     = 6;
  localparam int SLOT_W     = 4;
  localparam int PATH_AW    = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int PATH_CW    = $clog2(NUM_PATHS + 1);
  localparam int SLOT_DEPTH = NUM_PATHS * NUM_SLOTS;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    LVL_ZERO = 2'd0,
    LVL_ONE  = 2'd1,
    LVL_X    = 2'd2,
    LVL_Z    = 2'd3
  } level_t;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [PORT_W-1:0] src;
    logic [PORT_W-1:0] dst;
  } path_ports_t;

  typedef struct packed {
    logic [DELAY_WIDTH-1:0] delay;
    logic [DELAY_WIDTH-1:0] reject;
    logic [DELAY_WIDTH-1:0] error;
  } slot_values_t;

  // rows: from level, columns: to level (0, 1, x, z)
  localparam slot_t SLOT_MAP [4][4] = '{
    '{4'd0, 4'd0, 4'd6,  4'd2},
    '{4'd1, 4'd0, 4'd8,  4'd4},
    '{4'd9, 4'd7, 4'd0,  4'd10},
    '{4'd5, 4'd3, 4'd11, 4'd0}
  };

  function automatic slot_t slot_of(level_t from_lvl, level_t to_lvl);
    return SLOT_MAP[from_lvl][to_lvl];
  endfunction

endpackage

`default_nettype wire

### rtl/core/module_path_delay_select_top.sv
// module path delay select: path table in two rams, sequential scan per query
// depends on mpds_pkg, mpds_ram, mpds_classify
// a write request is stored on acceptance; a query request scans all 16 path entries
// (port/slot ram reads, one compare per entry, one load of the output register, which
// waits for out_ready while a result is held); the next request is taken after the load
// reset clears the path valid bits; slot values stay undefined until written
`default_nettype none

module module_path_delay_select_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [3:0]  entry_index,
  input  wire logic [3:0]  slot_index,
  input  wire logic [5:0]  source_port,
  input  wire logic [5:0]  port,
  input  wire logic [31:0] delay_value,
  input  wire logic [31:0] reject_value,
  input  wire logic [31:0] error_value,
  input  wire logic [63:0] source_mask,
  input  wire logic [63:0] from_value,
  input  wire logic [63:0] to_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output mpds_pkg::slot_t  slot,
  output logic [31:0]      delay_out,
  output logic [31:0]      reject_out,
  output logic [31:0]      error_out
);
  import mpds_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state;
  logic [NUM_PATHS-1:0]    valid;
  logic [PATH_CW-1:0]      cnt;
  logic                    cmp_vld;
  logic [PATH_AW-1:0]      cmp_idx;

  logic [PORT_W-1:0]       q_port;
  logic [63:0]             q_mask;
  slot_t                   q_slot;
  slot_t                   in_slot;

  logic                    best_found;
  logic [DELAY_WIDTH-1:0]  best_delay;
  logic [DELAY_WIDTH-1:0]  best_reject;
  logic [DELAY_WIDTH-1:0]  best_error;

  logic                    accept;
  logic                    wr_en;
  logic                    rd_en;
  logic                    hit;
  logic                    last_cmp;
  logic                    load_out;

  path_ports_t             port_wdata;
  path_ports_t             port_rdata;
  slot_values_t            slot_wdata;
  slot_values_t            slot_rdata;
  logic [SLOT_AW-1:0]      slot_waddr;
  logic [SLOT_AW-1:0]      slot_raddr;

  mpds_classify u_classify (
    .from_value (from_value),
    .to_value   (to_value),
    .slot       (in_slot)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // out-of-range writes leave the whole entry untouched
  assign wr_en = accept && (opcode == OP_WRITE) &&
                 (int'(entry_index) < NUM_PATHS) && (int'(slot_index) < NUM_SLOTS);

  assign port_wdata.src = source_port;
  assign port_wdata.dst = port;
  assign slot_wdata.delay  = DELAY_WIDTH'(delay_value);
  assign slot_wdata.reject = DELAY_WIDTH'(reject_value);
  assign slot_wdata.error  = DELAY_WIDTH'(error_value);
  assign slot_waddr = SLOT_AW'(int'(entry_index) * NUM_SLOTS + int'(slot_index));

  assign rd_en      = (state == S_SCAN) && (int'(cnt) < NUM_PATHS);
  assign slot_raddr = SLOT_AW'(int'(cnt) * NUM_SLOTS + int'(q_slot));

  mpds_ram #(
    .WIDTH ($bits(path_ports_t)),
    .DEPTH (NUM_PATHS)
  ) u_port_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (PATH_AW'(entry_index)),
    .wdata (port_wdata),
    .re    (rd_en),
    .raddr (PATH_AW'(cnt)),
    .rdata (port_rdata)
  );

  mpds_ram #(
    .WIDTH ($bits(slot_values_t)),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (rd_en),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // strict less-than keeps the lowest entry on a tie
  assign hit = cmp_vld && valid[cmp_idx] && (port_rdata.dst == q_port) &&
               q_mask[port_rdata.src] &&
               (!best_found || (slot_rdata.delay < best_delay));

  assign last_cmp = cmp_vld && !rd_en;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      cnt        <= '0;
      cmp_vld    <= 1'b0;
      out_valid  <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[PATH_AW'(entry_index)] <= 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      cmp_vld <= rd_en;
      if (rd_en) begin
        cmp_idx <= PATH_AW'(cnt);
        cnt     <= cnt + PATH_CW'(1);
      end

      if (hit) begin
        best_found  <= 1'b1;
        best_delay  <= slot_rdata.delay;
        best_reject <= slot_rdata.reject;
        best_error  <= slot_rdata.error;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && opcode == OP_QUERY) begin
            q_port      <= port;
            q_mask      <= source_mask;
            q_slot      <= in_slot;
            cnt         <= '0;
            best_found  <= 1'b0;
            best_delay  <= '0;
            best_reject <= '0;
            best_error  <= '0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_cmp) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            found      <= best_found;
            slot       <= q_slot;
            delay_out  <= 32'(best_delay);
            reject_out <= 32'(best_reject);
            error_out  <= 32'(best_error);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/mpds_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module mpds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/mpds_classify.sv
// reduces the from and to four-state values to levels and maps the pair to a slot
// depends on mpds_pkg
`default_nettype none

module mpds_classify (
  input  wire logic [63:0]    from_value,
  input  wire logic [63:0]    to_value,
  output mpds_pkg::slot_t     slot
);
  import mpds_pkg::*;

  function automatic level_t level_of(logic [63:0] v);
    logic [VEC_WIDTH-1:0] aval;
    logic [VEC_WIDTH-1:0] bval;
    level_t               lvl;
    aval = v[VEC_WIDTH-1:0];
    bval = v[32+VEC_WIDTH-1:32];
    if (aval == '0 && bval == {VEC_WIDTH{1'b1}}) begin
      lvl = LVL_Z;
    end else if (bval != '0) begin
      lvl = LVL_X;
    end else if (aval != '0) begin
      lvl = LVL_ONE;
    end else begin
      lvl = LVL_ZERO;
    end
    return lvl;
  endfunction

  assign slot = slot_of(level_of(from_value), level_of(to_value));

endmodule

`default_nettype wire
